/* hw/rtl/skc_pkg.sv */
// Shared types, codes and defaults for the sorted key set.
`default_nettype none

package skc_pkg;

	localparam int DEF_CAPACITY = 64;
	localparam int KEY_W        = 32;
	localparam int POS_W        = 6;
	localparam int COUNT_W      = 7;

	localparam logic [1:0] OP_SEARCH = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]              opcode;
		logic signed [KEY_W-1:0] key;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [POS_W-1:0]   position;
		logic [COUNT_W-1:0] count;
	} rsp_t;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic cmp;
		logic ins;
		logic del;
	} cell_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/skc_cell.sv */
// One entry of the key chain: holds a key, compares it, shifts with neighbors.
`default_nettype none

module skc_cell (
	input  wire logic                             clk,
	input  wire skc_pkg::cell_ctl_t               ctl,
	input  wire logic                             occ,
	input  wire logic signed [skc_pkg::KEY_W-1:0] probe,
	input  wire logic                             left_lt,
	input  wire logic signed [skc_pkg::KEY_W-1:0] left_key,
	input  wire logic signed [skc_pkg::KEY_W-1:0] right_key,
	output logic signed [skc_pkg::KEY_W-1:0]      cell_key,
	output logic                                  lt,
	output logic                                  eq
);

	logic signed [skc_pkg::KEY_W-1:0] key_q;
	logic                             lt_q;
	logic                             eq_q;

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			lt_q <= occ && (key_q < probe);
			eq_q <= occ && (key_q == probe);
		end
		// entries at and above the rank move; the boundary cell takes the new key
		if (ctl.ins && !lt_q) begin
			key_q <= left_lt ? probe : left_key;
		end else if (ctl.del && !lt_q) begin
			key_q <= right_key;
		end
	end

	assign cell_key = key_q;
	assign lt       = lt_q;
	assign eq       = eq_q;

endmodule

`default_nettype wire

/* hw/rtl/sorted_key_set.sv */
// Sorted key set: a chain of compare-and-shift cells with a small sequencer.
// The result is registered in the update state after the compare state
// (compare in every cell, then resolve rank and shift the chain).
// Commands stall until the last is done; the rank is resolved from the cell
// flags registered in the compare cycle. A stalled result holds the update.
// Reset clears the key count and sequencer; the cell keys are not reset.
`default_nettype none

module sorted_key_set #(
	parameter int CAPACITY = skc_pkg::DEF_CAPACITY
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	input  wire skc_pkg::cmd_t cmd,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output skc_pkg::rsp_t      rsp
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int PW    = (IDX_W > skc_pkg::POS_W) ? IDX_W : skc_pkg::POS_W;
	localparam int CW    = (CNT_W > skc_pkg::COUNT_W) ? CNT_W : skc_pkg::COUNT_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CMP  = 3'b010,
		S_UPD  = 3'b100
	} state_t;

	state_t                           state_q;
	logic [1:0]                       op_q;
	logic signed [skc_pkg::KEY_W-1:0] key_q;
	logic [CNT_W-1:0]                 count_q;
	logic                             rsp_valid_q;
	skc_pkg::rsp_t                    rsp_q;

	skc_pkg::cell_ctl_t               ctl;
	logic                             advance;
	logic [CAPACITY-1:0]              lt_w;
	logic [CAPACITY-1:0]              eq_w;
	logic signed [skc_pkg::KEY_W-1:0] key_w [CAPACITY];

	logic                             hit;
	logic                             full;
	logic [PW-1:0]                    rank;
	logic [1:0]                       status_d;
	logic [PW-1:0]                    pos_d;
	logic [CNT_W-1:0]                 count_d;
	logic [CW-1:0]                    count_ext;

	assign cmd_stall = (state_q != S_IDLE);
	assign advance   = (state_q == S_UPD) && !(rsp_valid_q && rsp_stall);
	assign full      = (count_q == CNT_W'(CAPACITY));

	// hit and the boundary index come from the flags the cells registered
	always_comb begin
		hit  = |eq_w;
		rank = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (!lt_w[i] && (i == 0 || lt_w[(i == 0) ? 0 : i - 1])) begin
				rank = rank | PW'(i);
			end
		end
	end

	always_comb begin
		ctl      = '0;
		ctl.cmp  = (state_q == S_CMP);
		status_d = skc_pkg::ST_OK;
		pos_d    = '0;
		count_d  = count_q;
		case (op_q)
			skc_pkg::OP_SEARCH: begin
				if (hit) pos_d = rank;
				else status_d = skc_pkg::ST_MISS;
			end
			skc_pkg::OP_INSERT: begin
				if (hit) begin
					status_d = skc_pkg::ST_MISS;
				end else if (full) begin
					status_d = skc_pkg::ST_FULL;
				end else begin
					ctl.ins = advance;
					pos_d   = rank;
					count_d = count_q + CNT_W'(1);
				end
			end
			skc_pkg::OP_DELETE: begin
				if (hit) begin
					ctl.del = advance;
					pos_d   = rank;
					count_d = count_q - CNT_W'(1);
				end else begin
					status_d = skc_pkg::ST_MISS;
				end
			end
			skc_pkg::OP_CLEAR: count_d = '0;
			default:           count_d = count_q;
		endcase
		count_ext = CW'(count_d);
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic                             occ;
		logic                             left_lt;
		logic signed [skc_pkg::KEY_W-1:0] left_key;
		logic signed [skc_pkg::KEY_W-1:0] right_key;

		assign occ = (CNT_W'(g) < count_q);
		if (g == 0) begin : g_first
			assign left_lt  = 1'b1;
			assign left_key = key_q;
		end else begin : g_mid
			assign left_lt  = lt_w[g-1];
			assign left_key = key_w[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_key = key_w[g];
		end else begin : g_inner
			assign right_key = key_w[g+1];
		end

		skc_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (occ),
			.probe     (key_q),
			.left_lt   (left_lt),
			.left_key  (left_key),
			.right_key (right_key),
			.cell_key  (key_w[g]),
			.lt        (lt_w[g]),
			.eq        (eq_w[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// a new result may replace one taken in the same cycle
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (cmd_valid) state_q <= S_CMP;
				S_CMP:  state_q <= S_UPD;
				S_UPD: begin
					if (advance) begin
						count_q <= count_d;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) begin
			op_q  <= cmd.opcode;
			key_q <= cmd.key;
		end
		if (advance) begin
			rsp_q.status   <= status_d;
			rsp_q.position <= pos_d[skc_pkg::POS_W-1:0];
			rsp_q.count    <= count_ext[skc_pkg::COUNT_W-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the sorted key set: directed table, then random op mixes.
`timescale 1ns / 100ps

module testbench;
	import skc_pkg::*;

	localparam int SET_CAP      = DEF_CAPACITY;
	localparam int RANDOM_ITEMS = 1930;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 20;

	localparam logic signed [KEY_W-1:0] MIN_KEY = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] MAX_KEY = 32'sh7FFF_FFFF;

	typedef enum int {GROW, SHRINK, CHURN} op_mix_e;

	typedef struct {
		cmd_t c;
		bit   typed;
		rsp_t r;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd_beat;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp_beat;

	// reference copy of the set, kept in ascending order
	logic signed [KEY_W-1:0] held_keys[$];
	rsp_t                    expected_rsp[$];
	stim_row_t               directed_rows[$];

	bit   beat_typed;
	rsp_t beat_typed_rsp;

	int snd_idle_pct;
	int rcv_stall_pct;
	int item_idx;
	int total_items;
	int errors;
	int results_checked;
	int quiet_cycles;
	int n_placed, n_dup, n_full, n_removed, n_clears, peak_count;

	sorted_key_set #(
		.CAPACITY(SET_CAP)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd_beat),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp_beat)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
	end

	// Applies one operation to the set copy and returns the result it should give.
	function automatic rsp_t apply_set_op(cmd_t c);
		rsp_t                    r;
		logic signed [KEY_W-1:0] k;
		int                      rank;
		bit                      hit;
		r.status   = ST_OK;
		r.position = '0;
		k          = c.key;
		if (c.opcode == OP_CLEAR) begin
			held_keys.delete();
			n_clears++;
		end else begin
			rank = 0;
			while (rank < held_keys.size() && held_keys[rank] < k)
				rank++;
			hit = (rank < held_keys.size()) && (held_keys[rank] == k);
			case (c.opcode)
				OP_SEARCH: begin
					if (hit)
						r.position = POS_W'(rank);
					else
						r.status = ST_MISS;
				end
				OP_INSERT: begin
					// duplicate wins over full
					if (hit) begin
						r.status = ST_MISS;
						n_dup++;
					end else if (held_keys.size() >= SET_CAP) begin
						r.status = ST_FULL;
						n_full++;
					end else begin
						held_keys.insert(rank, k);
						r.position = POS_W'(rank);
						n_placed++;
					end
				end
				default: begin
					if (!hit) begin
						r.status = ST_MISS;
					end else begin
						held_keys.delete(rank);
						r.position = POS_W'(rank);
						n_removed++;
					end
				end
			endcase
		end
		r.count = COUNT_W'(held_keys.size());
		if (held_keys.size() > peak_count)
			peak_count = held_keys.size();
		return r;
	endfunction

	function automatic logic signed [KEY_W-1:0] pick_key(int held_pct);
		int sel;
		sel = $urandom_range(99);
		if (sel < held_pct && held_keys.size() > 0)
			return held_keys[$urandom_range(held_keys.size() - 1)];
		sel = $urandom_range(99);
		if (sel < 30)
			return 32'($urandom_range(40)) - 32'd20;
		if (sel < 45) begin
			case ($urandom_range(3))
				0: return MIN_KEY;
				1: return MAX_KEY;
				2: return {1'b1, 31'($urandom_range(3))};
				default: return {1'b0, ~31'($urandom_range(3))};
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic [1:0] pick_op(op_mix_e mix);
		int w;
		w = $urandom_range(99);
		case (mix)
			GROW:    return (w < 75) ? OP_INSERT : (w < 90) ? OP_SEARCH : OP_DELETE;
			SHRINK:  return (w < 70) ? OP_DELETE : (w < 90) ? OP_SEARCH : OP_INSERT;
			default: return (w < 30) ? OP_SEARCH : (w < 63) ? OP_INSERT :
			                (w < 96) ? OP_DELETE : OP_CLEAR;
		endcase
	endfunction

	task automatic add_row(input logic [1:0] op, input logic signed [KEY_W-1:0] k,
			input bit typed, input logic [1:0] st, input int pos, input int cnt);
		stim_row_t row;
		row.c.opcode     = op;
		row.c.key        = k;
		row.typed        = typed;
		row.r.status     = st;
		row.r.position   = POS_W'(pos);
		row.r.count      = COUNT_W'(cnt);
		directed_rows.push_back(row);
	endtask

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_cmd(input cmd_t c, input bit typed, input rsp_t typed_rsp);
		if (item_idx < total_items / 3) begin
			snd_idle_pct  = 17;
			rcv_stall_pct = 81;
		end else if (item_idx < 2 * total_items / 3) begin
			snd_idle_pct  = 81;
			rcv_stall_pct = 17;
		end else begin
			snd_idle_pct  = 0;
			rcv_stall_pct = 0;
		end
		while ($urandom_range(99) < snd_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid      <= 1'b1;
		cmd_beat       <= c;
		beat_typed     = typed;
		beat_typed_rsp = typed_rsp;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		item_idx++;
		@(negedge clk);
	endtask

	// Result checking, prediction on command accept, and the hang watchdog.
	always @(posedge clk) begin : check_results
		rsp_t want;
		rsp_t predicted;
		bit   moved;
		if (arst_n) begin
			moved = 1'b0;
			if (rsp_valid && !rsp_stall) begin
				moved = 1'b1;
				if (expected_rsp.size() == 0) begin
					$error("result beat with nothing outstanding: %h", rsp_beat);
					errors++;
				end else begin
					want = expected_rsp.pop_front();
					results_checked++;
					if (rsp_beat.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_beat.status);
						errors++;
					end
					if (rsp_beat.position !== want.position) begin
						$error("position: expected %0d, got %0d",
							want.position, rsp_beat.position);
						errors++;
					end
					if (rsp_beat.count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, rsp_beat.count);
						errors++;
					end
				end
			end
			if (cmd_valid && !cmd_stall) begin
				moved = 1'b1;
				predicted = apply_set_op(cmd_beat);
				expected_rsp.push_back(beat_typed ? beat_typed_rsp : predicted);
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no beat for %0d cycles", QUIET_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin : stimulus
		cmd_t    c;
		rsp_t    dummy;
		op_mix_e mix;
		int      run_len;
		int      sent_random;
		arst_n        = 1'b0;
		cmd_valid     = 1'b0;
		cmd_beat      = '0;
		rsp_stall     = 1'b0;
		beat_typed    = 1'b0;
		beat_typed_rsp = '0;
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		dummy         = '0;

		// after reset, extremes, duplicates, misses; untyped rows go to the predictor
		add_row(OP_SEARCH, 0,       1, ST_MISS, 0, 0);
		add_row(OP_DELETE, MAX_KEY, 1, ST_MISS, 0, 0);
		add_row(OP_CLEAR,  -1,      1, ST_OK,   0, 0);
		add_row(OP_INSERT, MAX_KEY, 1, ST_OK,   0, 1);
		add_row(OP_INSERT, MIN_KEY, 1, ST_OK,   0, 2);
		add_row(OP_INSERT, 0,       1, ST_OK,   1, 3);
		add_row(OP_INSERT, -1,      1, ST_OK,   1, 4);
		add_row(OP_INSERT, 0,       1, ST_MISS, 0, 4);
		add_row(OP_SEARCH, MAX_KEY, 1, ST_OK,   3, 4);
		add_row(OP_SEARCH, MIN_KEY, 1, ST_OK,   0, 4);
		add_row(OP_SEARCH, 1,       1, ST_MISS, 0, 4);
		add_row(OP_DELETE, 0,       1, ST_OK,   2, 3);
		add_row(OP_DELETE, 0,       1, ST_MISS, 0, 3);
		add_row(OP_INSERT, 32'sh5555_5555, 0, ST_OK, 0, 0);
		add_row(OP_INSERT, 32'shAAAA_AAAA, 0, ST_OK, 0, 0);
		add_row(OP_SEARCH, 32'sh5555_5555, 0, ST_OK, 0, 0);
		add_row(OP_DELETE, MIN_KEY, 0, ST_OK, 0, 0);
		add_row(OP_DELETE, MAX_KEY, 0, ST_OK, 0, 0);
		add_row(OP_CLEAR,  MAX_KEY, 1, ST_OK,   0, 0);
		add_row(OP_SEARCH, MIN_KEY, 1, ST_MISS, 0, 0);
		total_items = directed_rows.size() + RANDOM_ITEMS;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_cmd(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].r);

		// runs of one op mix; grow runs are long enough to reach a full store
		sent_random = 0;
		while (sent_random < RANDOM_ITEMS) begin
			mix     = op_mix_e'($urandom_range(2));
			run_len = (mix == GROW) ? $urandom_range(100, 200) : $urandom_range(30, 120);
			while (run_len > 0 && sent_random < RANDOM_ITEMS) begin
				c.opcode = pick_op(mix);
				c.key    = pick_key((mix == GROW) ? 15 : 50);
				send_cmd(c, 1'b0, dummy);
				run_len--;
				sent_random++;
			end
		end
		cmd_valid <= 1'b0;

		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d commands, %0d results checked; peak count %0d of %0d, %0d clears",
			item_idx, results_checked, peak_count, SET_CAP, n_clears);
		$display("inserts: %0d placed, %0d duplicate, %0d on full store; %0d keys removed",
			n_placed, n_dup, n_full, n_removed);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
